@@ rtl/core/mecanum_mix_pi_speed_control_defines.svh @@
// Assertion macros shared by the mecanum mixer and PI speed loop RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MECANUM_MIX_PI_SPEED_CONTROL_DEFINES_SVH
`define MECANUM_MIX_PI_SPEED_CONTROL_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define MMPSC_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define MMPSC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ rtl/core/mmpsc_pkg.sv @@
// Package of the mecanum mixer and PI speed loop: widths, lane indices,
// register codes and the control structs. No dependencies.
package mmpsc_pkg;

    localparam int WHEEL_COUNT     = 4;
    localparam int DRIVE_LIMIT_DEF = 30000;
    localparam logic [14:0] INTEG_LIMIT_RESET = 15'd12000;

    localparam int CMD_W   = 15;
    localparam int SPEED_W = 16;
    localparam int SETPT_W = 17;
    localparam int ERR_W   = 18;
    localparam int DRIVE_W = 16;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Wheel lane order.
    localparam int LANE_FR = 0;
    localparam int LANE_BR = 1;
    localparam int LANE_FL = 2;
    localparam int LANE_BL = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 2'd0,
        CFG_INTEG_GAIN  = 2'd1,
        CFG_INTEG_LIMIT = 2'd2,
        CFG_UNUSED      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [LIMIT_W-1:0] integ_limit;
    } t_gain_cfg;

    // Load strobes of the four pipeline stages, shared by all lanes.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_lane_ctrl;

    typedef logic signed [SETPT_W-1:0] t_setpt;

endpackage

@@ rtl/core/mmpsc_mixer.sv @@
// Mecanum mixing of strafe, drive and turn commands into four wheel setpoints.
// Depends on mmpsc_pkg.
module mmpsc_mixer (
    input  logic signed [mmpsc_pkg::CMD_W-1:0] i_strafe,
    input  logic signed [mmpsc_pkg::CMD_W-1:0] i_drive,
    input  logic signed [mmpsc_pkg::CMD_W-1:0] i_turn,
    output mmpsc_pkg::t_setpt                  o_setpt [mmpsc_pkg::WHEEL_COUNT]
);

    mmpsc_pkg::t_setpt s_ext;
    mmpsc_pkg::t_setpt d_ext;
    mmpsc_pkg::t_setpt h_ext;

    assign s_ext = mmpsc_pkg::SETPT_W'(i_strafe);
    assign d_ext = mmpsc_pkg::SETPT_W'(i_drive);
    assign h_ext = mmpsc_pkg::SETPT_W'(i_turn);

    // Three 15-bit terms always fit in 17 signed bits.
    assign o_setpt[mmpsc_pkg::LANE_FR] =  s_ext - d_ext + h_ext;
    assign o_setpt[mmpsc_pkg::LANE_BR] = -s_ext - d_ext + h_ext;
    assign o_setpt[mmpsc_pkg::LANE_FL] =  s_ext + d_ext + h_ext;
    assign o_setpt[mmpsc_pkg::LANE_BL] = -s_ext + d_ext + h_ext;

endmodule

@@ rtl/core/mmpsc_lane.sv @@
// One wheel PI lane: error, gain products, integrator update, drive clamp.
// Depends on mmpsc_pkg.
module mmpsc_lane #(
    parameter int DRIVE_LIMIT = mmpsc_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mmpsc_pkg::t_lane_ctrl                 i_ctrl,
    input  mmpsc_pkg::t_gain_cfg                  i_cfg,
    input  mmpsc_pkg::t_setpt                     i_setpt,
    input  logic signed [mmpsc_pkg::SPEED_W-1:0]  i_speed,
    output logic signed [mmpsc_pkg::DRIVE_W-1:0]  o_drive
);

    localparam int PROD_W = mmpsc_pkg::ERR_W + mmpsc_pkg::GAIN_W + 1;
    localparam int SHR_W  = PROD_W - 8;
    localparam int ACC_W  = SHR_W + 1;
    localparam logic signed [ACC_W-1:0] DRV_MAX = ACC_W'(DRIVE_LIMIT);
    localparam logic signed [ACC_W-1:0] DRV_MIN = -DRV_MAX;

    logic signed [mmpsc_pkg::ERR_W-1:0]   r_err;
    logic signed [SHR_W-1:0]              r_pi_p;
    logic signed [SHR_W-1:0]              r_pi_i;
    logic signed [SHR_W-1:0]              r_pp3;
    logic signed [mmpsc_pkg::DRIVE_W-1:0] r_integ;
    logic signed [mmpsc_pkg::DRIVE_W-1:0] r_drive;

    logic signed [mmpsc_pkg::ERR_W-1:0]   n_err;
    logic signed [PROD_W-1:0]             n_prod_p;
    logic signed [PROD_W-1:0]             n_prod_i;
    logic signed [ACC_W-1:0]              n_acc;
    logic signed [ACC_W-1:0]              lim_pos;
    logic signed [ACC_W-1:0]              lim_neg;
    logic signed [mmpsc_pkg::DRIVE_W-1:0] n_integ;
    logic signed [ACC_W-1:0]              n_sum;
    logic signed [mmpsc_pkg::DRIVE_W-1:0] n_drive;

    assign n_err = mmpsc_pkg::ERR_W'(i_setpt) - mmpsc_pkg::ERR_W'(i_speed);

    // Gains are unsigned, so a zero bit on top makes them positive signed factors.
    assign n_prod_p = PROD_W'(r_err) * PROD_W'($signed({1'b0, i_cfg.prop_gain}));
    assign n_prod_i = PROD_W'(r_err) * PROD_W'($signed({1'b0, i_cfg.integ_gain}));

    assign lim_pos = $signed({{(ACC_W-mmpsc_pkg::LIMIT_W){1'b0}}, i_cfg.integ_limit});
    assign lim_neg = -lim_pos;
    assign n_acc   = ACC_W'(r_integ) + ACC_W'(r_pi_i);

    always_comb begin
        priority if (n_acc > lim_pos) begin
            n_integ = mmpsc_pkg::DRIVE_W'(lim_pos);
        end else if (n_acc < lim_neg) begin
            n_integ = mmpsc_pkg::DRIVE_W'(lim_neg);
        end else begin
            n_integ = mmpsc_pkg::DRIVE_W'(n_acc);
        end
    end

    // r_integ already holds this item's updated integrator when stage four loads.
    assign n_sum = ACC_W'(r_pp3) + ACC_W'(r_integ);

    always_comb begin
        priority if (n_sum > DRV_MAX) begin
            n_drive = mmpsc_pkg::DRIVE_W'(DRV_MAX);
        end else if (n_sum < DRV_MIN) begin
            n_drive = mmpsc_pkg::DRIVE_W'(DRV_MIN);
        end else begin
            n_drive = mmpsc_pkg::DRIVE_W'(n_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld1) begin
            r_err <= n_err;
        end
        if (i_ctrl.ld2) begin
            // Arithmetic shift right by eight rounds toward minus infinity.
            r_pi_p <= $signed(n_prod_p[PROD_W-1:8]);
            r_pi_i <= $signed(n_prod_i[PROD_W-1:8]);
        end
        if (i_ctrl.ld3) begin
            r_pp3 <= r_pi_p;
        end
        if (i_ctrl.ld4) begin
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_ctrl.ld3) begin
            r_integ <= n_integ;
        end
    end

    assign o_drive = r_drive;

endmodule

@@ rtl/core/mecanum_mix_pi_speed_control.sv @@
// Top level of the mecanum wheel mixer with four PI wheel speed loops.
// Depends on mmpsc_pkg, mmpsc_mixer, mmpsc_lane and the shared defines header.
//
// Each accepted item is one control tick: three velocity commands and four
// measured wheel speeds. The block accepts one item per clock cycle unless
// stalled. The result item of four saturated motor drives is valid in the last
// stage and leaves when the output is ready. Four identical lanes, one per
// wheel, run a four-stage pipeline: mixing and error, the two gain multiplies,
// the integrator update with its clamp, and the drive sum with its clamp.
// Stage three's integrator feedback sets the rate. Every stage has its own
// valid bit and fills empty slots while the output waits, so input is refused
// only when all four stages hold items. Gains and the integrator limit are
// written through the configuration port while the block is idle, a rule for
// the user that the block does not enforce; integrators reset to zero.
`include "mecanum_mix_pi_speed_control_defines.svh"

module mecanum_mix_pi_speed_control #(
    parameter int DRIVE_LIMIT = mmpsc_pkg::DRIVE_LIMIT_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_cfg_wr_en,
    input  logic [mmpsc_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mmpsc_pkg::CFG_DATA_W-1:0]        i_cfg_wdata,

    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [mmpsc_pkg::CMD_W-1:0]      i_strafe_cmd,
    input  logic signed [mmpsc_pkg::CMD_W-1:0]      i_drive_cmd,
    input  logic signed [mmpsc_pkg::CMD_W-1:0]      i_turn_cmd,
    input  logic signed [mmpsc_pkg::SPEED_W-1:0]    i_speed_front_right,
    input  logic signed [mmpsc_pkg::SPEED_W-1:0]    i_speed_back_right,
    input  logic signed [mmpsc_pkg::SPEED_W-1:0]    i_speed_front_left,
    input  logic signed [mmpsc_pkg::SPEED_W-1:0]    i_speed_back_left,

    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [mmpsc_pkg::DRIVE_W-1:0]    o_drive_front_right,
    output logic signed [mmpsc_pkg::DRIVE_W-1:0]    o_drive_front_left,
    output logic signed [mmpsc_pkg::DRIVE_W-1:0]    o_drive_back_left,
    output logic signed [mmpsc_pkg::DRIVE_W-1:0]    o_drive_back_right
);

    localparam logic signed [mmpsc_pkg::DRIVE_W-1:0] DRV_MAX =
        mmpsc_pkg::DRIVE_W'(DRIVE_LIMIT);
    localparam logic signed [mmpsc_pkg::DRIVE_W-1:0] DRV_MIN = -DRV_MAX;

    // Configuration registers.
    logic [mmpsc_pkg::GAIN_W-1:0]  r_prop_gain;
    logic [mmpsc_pkg::GAIN_W-1:0]  r_integ_gain;
    logic [mmpsc_pkg::LIMIT_W-1:0] r_integ_limit;
    mmpsc_pkg::t_gain_cfg          gain_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= '0;
            r_integ_gain  <= '0;
            r_integ_limit <= mmpsc_pkg::INTEG_LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (mmpsc_pkg::t_cfg_idx'(i_cfg_index))
                mmpsc_pkg::CFG_PROP_GAIN: begin
                    r_prop_gain <= i_cfg_wdata;
                end
                mmpsc_pkg::CFG_INTEG_GAIN: begin
                    r_integ_gain <= i_cfg_wdata;
                end
                mmpsc_pkg::CFG_INTEG_LIMIT: begin
                    r_integ_limit <= i_cfg_wdata[mmpsc_pkg::LIMIT_W-1:0];
                end
                default: begin
                    // Writes to an unknown index are dropped.
                end
            endcase
        end
    end

    assign gain_cfg.prop_gain   = r_prop_gain;
    assign gain_cfg.integ_gain  = r_integ_gain;
    assign gain_cfg.integ_limit = r_integ_limit;

    // Pipeline occupancy. A stage may take a new item when it is empty or
    // when the item it holds moves on in the same cycle.
    logic r_v1, r_v2, r_v3, r_v4;
    logic adv1, adv2, adv3, adv4;
    mmpsc_pkg::t_lane_ctrl lane_ctrl;

    assign adv4 = !r_v4 || i_out_ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign lane_ctrl.ld1 = i_in_valid && adv1;
    assign lane_ctrl.ld2 = r_v1 && adv2;
    assign lane_ctrl.ld3 = r_v2 && adv3;
    assign lane_ctrl.ld4 = r_v3 && adv4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_in_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign o_in_ready  = adv1;
    assign o_out_valid = r_v4;

    // Mixing feeds the first stage of every lane.
    mmpsc_pkg::t_setpt setpt [mmpsc_pkg::WHEEL_COUNT];
    logic signed [mmpsc_pkg::SPEED_W-1:0] speed [mmpsc_pkg::WHEEL_COUNT];
    logic signed [mmpsc_pkg::DRIVE_W-1:0] drive [mmpsc_pkg::WHEEL_COUNT];

    mmpsc_mixer u_mixer (
        .i_strafe (i_strafe_cmd),
        .i_drive  (i_drive_cmd),
        .i_turn   (i_turn_cmd),
        .o_setpt  (setpt)
    );

    assign speed[mmpsc_pkg::LANE_FR] = i_speed_front_right;
    assign speed[mmpsc_pkg::LANE_BR] = i_speed_back_right;
    assign speed[mmpsc_pkg::LANE_FL] = i_speed_front_left;
    assign speed[mmpsc_pkg::LANE_BL] = i_speed_back_left;

    for (genvar g = 0; g < mmpsc_pkg::WHEEL_COUNT; g++) begin : g_lane
        mmpsc_lane #(
            .DRIVE_LIMIT (DRIVE_LIMIT)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (lane_ctrl),
            .i_cfg   (gain_cfg),
            .i_setpt (setpt[g]),
            .i_speed (speed[g]),
            .o_drive (drive[g])
        );
    end

    // Merge the lane results into the result item in its field order.
    assign o_drive_front_right = drive[mmpsc_pkg::LANE_FR];
    assign o_drive_front_left  = drive[mmpsc_pkg::LANE_FL];
    assign o_drive_back_left   = drive[mmpsc_pkg::LANE_BL];
    assign o_drive_back_right  = drive[mmpsc_pkg::LANE_BR];

    // Input may only be refused when every stage holds an item.
    `MMPSC_ASSERT_CLK(a_full_when_stalled,
        !o_in_ready |-> (r_v1 && r_v2 && r_v3 && r_v4),
        "input refused with a free stage")
    // An accepted item occupies the first stage in the next cycle.
    `MMPSC_ASSERT_CLK(a_accept_fills,
        (i_in_valid && o_in_ready) |=> r_v1,
        "accepted item lost")
    // The delivered front-right and back-left drives stay within the drive limit.
    `MMPSC_ASSERT_CLK(a_drive_range,
        o_out_valid |-> (o_drive_front_right <= DRV_MAX && o_drive_front_right >= DRV_MIN
            && o_drive_back_left <= DRV_MAX && o_drive_back_left >= DRV_MIN),
        "drive out of range")
    // Reset empties the output stage.
    `MMPSC_ASSERT_ALWAYS(a_reset_empty,
        !i_rst_n |=> !o_out_valid,
        "output valid after reset")

endmodule
